### sv/assert_macros.svh
// Assertion helpers for the RTL file that carries checks.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/ipcm_pkg.sv
// Shared types and constants for the IPv4 frame classifier and payload match unit.
// No dependencies; the front end, queue, back end and top file import this package.
`default_nettype none

package ipcm_pkg;

	localparam int ETH_HDR_BYTES  = 14;
	localparam int MIN_HDR_BYTES  = 20;
	localparam int SMALL_L4_BYTES = 8;

	localparam logic [15:0] TYPE_IPV4 = 16'h0800;
	localparam logic [15:0] TYPE_ARP  = 16'h0806;
	localparam logic [7:0]  PROTO_ICMP = 8'd1;
	localparam logic [7:0]  PROTO_TCP  = 8'd6;
	localparam logic [7:0]  PROTO_UDP  = 8'd17;
	localparam logic [7:0]  IHL_MASK   = 8'h0f;
	localparam logic [7:0]  DOFF_MASK  = 8'hf0;
	localparam logic [15:0] POS_MAX    = 16'hffff;

	// byte positions of the header fields within the frame
	localparam logic [15:0] POS_ETYPE_HI = 16'd12;
	localparam logic [15:0] POS_ETYPE_LO = 16'd13;
	localparam logic [15:0] POS_IHL      = 16'd14;
	localparam logic [15:0] POS_TLEN_HI  = 16'd16;
	localparam logic [15:0] POS_TLEN_LO  = 16'd17;
	localparam logic [15:0] POS_PROTO    = 16'd23;
	localparam logic [15:0] POS_TCP_MIN  = 16'd24;
	// TCP data offset sits 12 bytes into the TCP header
	localparam int TCP_DOFF_REL = 12;
	localparam int TCP_NEED_REL = 13;

	typedef enum logic [2:0] {
		CLS_OTHER = 3'd0,
		CLS_ARP   = 3'd1,
		CLS_TCP   = 3'd2,
		CLS_UDP   = 3'd3,
		CLS_ICMP  = 3'd4,
		CLS_IPV4  = 3'd5
	} class_t;

	typedef enum logic [1:0] {
		ERR_NONE    = 2'd0,
		ERR_IP_HDR  = 2'd1,
		ERR_TCP_HDR = 2'd2
	} hdr_err_t;

	typedef enum logic [1:0] {
		REG_PLEN   = 2'd0,
		REG_PWORD0 = 2'd1,
		REG_PWORD1 = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [3:0]  pattern_length;
		logic [31:0] pattern_first_word;
		logic [31:0] pattern_second_word;
	} cfg_t;

	// one frame byte with its search flag and, for the last byte, the layout verdict
	typedef struct packed {
		logic [7:0]  data;
		logic        last;
		logic        search;
		class_t      cls;
		hdr_err_t    err;
		logic        truncated;
		logic [7:0]  offset;
		logic [15:0] length;
	} qent_t;

	typedef struct packed {
		class_t      frame_class;
		hdr_err_t    header_error;
		logic        truncated;
		logic [7:0]  payload_offset;
		logic [15:0] payload_length;
		logic        pattern_found;
		logic        frame_pass;
	} verdict_t;

endpackage

`default_nettype wire

### sv/ipcm_if.sv
// Stream interfaces for frame bytes in and verdicts out (valid/ready).
// Depends on nothing; field widths follow the block's item formats.
`default_nettype none

interface ipcm_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       frame_last;

	modport source (output valid, output frame_byte, output frame_last, input ready);
	modport sink (input valid, input frame_byte, input frame_last, output ready);
endinterface

interface ipcm_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  frame_class;
	logic [1:0]  header_error;
	logic        truncated;
	logic [7:0]  payload_offset;
	logic [15:0] payload_length;
	logic        pattern_found;
	logic        frame_pass;

	modport source (output valid, output frame_class, output header_error, output truncated,
		output payload_offset, output payload_length, output pattern_found,
		output frame_pass, input ready);
	modport sink (input valid, input frame_class, input header_error, input truncated,
		input payload_offset, input payload_length, input pattern_found,
		input frame_pass, output ready);
endinterface

`default_nettype wire

### sv/ipcm_front.sv
// Front end: header parser and layout classifier, one frame byte per cycle while the queue has room.
// Depends on ipcm_pkg; feeds tagged bytes into ipcm_queue.
`default_nettype none

module ipcm_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [7:0]      in_byte,
	input  logic            in_last,
	output logic            in_ready,
	output logic            push_valid,
	output ipcm_pkg::qent_t push_data,
	input  logic            push_ready
);
	import ipcm_pkg::*;

	logic [15:0] pos_q, etype_q, tlen_q;
	logic [3:0]  ihl_q, doff_q;
	logic [7:0]  proto_q;

	logic [15:0] etype_n, tlen_n;
	logic [3:0]  ihl_n, doff_n;
	logic [7:0]  proto_n;

	logic        is_ipv4, is_tcp, ihl_ok, good;
	logic [5:0]  sip, tcp_bytes, trans;
	logic [6:0]  hdrs;
	logic [7:0]  doff_pos, off_full, off;
	logic [15:0] len_full, len;
	logic [16:0] need, end_excl, length;
	class_t      cls;
	hdr_err_t    err;
	logic        accept;

	assign accept     = in_valid && in_ready;
	assign in_ready   = push_ready;
	assign push_valid = in_valid;

	always_comb begin
		etype_n = etype_q;
		tlen_n  = tlen_q;
		ihl_n   = ihl_q;
		proto_n = proto_q;
		doff_n  = doff_q;
		case (pos_q)
			POS_ETYPE_HI: etype_n[15:8] = in_byte;
			POS_ETYPE_LO: etype_n[7:0] = in_byte;
			POS_IHL:      ihl_n = 4'(in_byte & IHL_MASK);
			POS_TLEN_HI:  tlen_n[15:8] = in_byte;
			POS_TLEN_LO:  tlen_n[7:0] = in_byte;
			POS_PROTO:    proto_n = in_byte;
			default:      ;
		endcase

		is_ipv4  = etype_n == TYPE_IPV4;
		is_tcp   = proto_n == PROTO_TCP;
		sip      = {ihl_n, 2'b00};
		ihl_ok   = sip >= 6'(MIN_HDR_BYTES);
		doff_pos = 8'(ETH_HDR_BYTES) + {2'b00, sip} + 8'(TCP_DOFF_REL);
		if (is_ipv4 && is_tcp && ihl_ok && pos_q >= POS_TCP_MIN &&
				pos_q == {8'b0, doff_pos})
			doff_n = 4'((in_byte & DOFF_MASK) >> 4);

		tcp_bytes = {doff_n, 2'b00};
		if (etype_n == TYPE_ARP)
			cls = CLS_ARP;
		else if (!is_ipv4)
			cls = CLS_OTHER;
		else if (is_tcp)
			cls = CLS_TCP;
		else if (proto_n == PROTO_UDP)
			cls = CLS_UDP;
		else if (proto_n == PROTO_ICMP)
			cls = CLS_ICMP;
		else
			cls = CLS_IPV4;

		case (cls)
			CLS_TCP:          trans = tcp_bytes;
			CLS_UDP, CLS_ICMP: trans = 6'(SMALL_L4_BYTES);
			default:          trans = '0;
		endcase

		if (is_ipv4 && !ihl_ok)
			err = ERR_IP_HDR;
		else if (is_ipv4 && is_tcp && tcp_bytes < 6'(MIN_HDR_BYTES))
			err = ERR_TCP_HDR;
		else
			err = ERR_NONE;

		hdrs     = {1'b0, sip} + {1'b0, trans};
		off_full = 8'(ETH_HDR_BYTES) + {1'b0, hdrs};
		len_full = (tlen_n > {9'b0, hdrs}) ? tlen_n - {9'b0, hdrs} : '0;
		good     = is_ipv4 && err == ERR_NONE;
		off      = good ? off_full : '0;
		len      = good ? len_full : '0;
		end_excl = {9'b0, off} + {1'b0, len};

		if (!is_ipv4)
			need = 17'(ETH_HDR_BYTES);
		else if (err == ERR_IP_HDR)
			need = 17'(ETH_HDR_BYTES + 1);
		else if (err == ERR_TCP_HDR)
			need = 17'(ETH_HDR_BYTES) + {11'b0, sip} + 17'(TCP_NEED_REL);
		else
			need = end_excl;

		length = {1'b0, pos_q} + 17'd1;

		push_data.data   = in_byte;
		push_data.last   = in_last;
		push_data.search = good && pos_q != POS_MAX && pos_q >= {8'b0, off} &&
			{1'b0, pos_q} < end_excl;
		if (length < 17'(ETH_HDR_BYTES)) begin
			push_data.cls       = CLS_OTHER;
			push_data.err       = ERR_NONE;
			push_data.offset    = '0;
			push_data.length    = '0;
			push_data.truncated = 1'b1;
		end else begin
			push_data.cls       = cls;
			push_data.err       = err;
			push_data.offset    = off;
			push_data.length    = len;
			push_data.truncated = length < need;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			etype_q <= '0;
			tlen_q  <= '0;
			ihl_q   <= '0;
			proto_q <= '0;
			doff_q  <= '0;
		end else if (accept) begin
			if (in_last) begin
				pos_q   <= '0;
				etype_q <= '0;
				tlen_q  <= '0;
				ihl_q   <= '0;
				proto_q <= '0;
				doff_q  <= '0;
			end else begin
				pos_q   <= (pos_q == POS_MAX) ? pos_q : pos_q + 16'd1;
				etype_q <= etype_n;
				tlen_q  <= tlen_n;
				ihl_q   <= ihl_n;
				proto_q <= proto_n;
				doff_q  <= doff_n;
			end
		end
	end

endmodule

`default_nettype wire

### sv/ipcm_queue.sv
// Short register FIFO between the parser front end and the match back end.
// Depends on ipcm_pkg for the entry type.
`default_nettype none

module ipcm_queue #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	input  ipcm_pkg::qent_t push_data,
	output logic            push_ready,
	output logic            pop_valid,
	output ipcm_pkg::qent_t pop_data,
	input  logic            pop_ready
);
	import ipcm_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	qent_t          mem_q [DEPTH];
	logic [AW-1:0]  wr_q, rd_q;
	logic [CW-1:0]  count_q;
	logic           push, pop;

	assign push_ready = count_q != CW'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = mem_q[rd_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

### sv/ipcm_back.sv
// Back end: sliding-window pattern match over payload bytes and verdict register.
// Depends on ipcm_pkg; drains ipcm_queue.
`default_nettype none

module ipcm_back #(
	parameter int MAX_PATTERN_BYTES = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  ipcm_pkg::qent_t   q_data,
	output logic              q_ready,
	input  ipcm_pkg::cfg_t    cfg,
	output logic              out_valid,
	output ipcm_pkg::verdict_t out_data,
	input  logic              out_ready
);
	import ipcm_pkg::*;

	localparam int WIN_W = 8 * MAX_PATTERN_BYTES;
	localparam int CNT_W = $clog2(MAX_PATTERN_BYTES + 1);

	logic [WIN_W-1:0] recent_q, recent_n;
	logic [CNT_W-1:0] seen_q, seen_n, plen;
	logic             zero_q, match_q;
	logic             pop, do_search, is_zero, hit, match_now, filtering, found;
	logic [7:0]       pat [8];
	logic [3:0]       pidx;

	assign q_ready   = !q_data.last || !out_valid || out_ready;
	assign pop       = q_valid && q_ready;
	assign do_search = pop && q_data.search && !zero_q;
	assign is_zero   = q_data.data == 8'd0;
	assign filtering = cfg.pattern_length != 4'd0;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			pat[i]     = cfg.pattern_first_word[8*i +: 8];
			pat[i + 4] = cfg.pattern_second_word[8*i +: 8];
		end
		plen = (cfg.pattern_length > 4'(MAX_PATTERN_BYTES)) ?
			CNT_W'(MAX_PATTERN_BYTES) : cfg.pattern_length[CNT_W-1:0];
		recent_n = WIN_W'({recent_q, q_data.data});
		seen_n   = (seen_q == CNT_W'(MAX_PATTERN_BYTES)) ? seen_q : seen_q + 1'b1;
		// window byte k (k = 0 newest) must equal pattern byte plen-1-k
		hit = plen != '0 && seen_n >= plen;
		for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
			pidx = 4'(plen) - 4'd1 - 4'(k);
			if (CNT_W'(k) < plen && recent_n[8*k +: 8] != pat[pidx[2:0]])
				hit = 1'b0;
		end
		match_now = match_q || (do_search && !is_zero && hit);
		found = filtering && match_now && !q_data.truncated &&
			q_data.cls >= CLS_TCP && q_data.err == ERR_NONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recent_q  <= '0;
			seen_q    <= '0;
			zero_q    <= 1'b0;
			match_q   <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (pop && q_data.last) begin
				recent_q  <= '0;
				seen_q    <= '0;
				zero_q    <= 1'b0;
				match_q   <= 1'b0;
				out_valid <= 1'b1;
			end else begin
				if (out_ready)
					out_valid <= 1'b0;
				if (do_search) begin
					if (is_zero) begin
						zero_q <= 1'b1;
					end else begin
						recent_q <= recent_n;
						seen_q   <= seen_n;
						if (hit)
							match_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && q_data.last) begin
			out_data.frame_class    <= q_data.cls;
			out_data.header_error   <= q_data.err;
			out_data.truncated      <= q_data.truncated;
			out_data.payload_offset <= q_data.offset;
			out_data.payload_length <= q_data.length;
			out_data.pattern_found  <= found;
			out_data.frame_pass     <= !filtering || found;
		end
	end

endmodule

`default_nettype wire

### sv/ipv4_packet_classifier_with_match_unit.sv
// A frame's last byte passes through the FIFO; its pop loads the verdict register.
// Throughput: one frame byte per cycle while the FIFO has room; parser and match
// engine are parted by a QUEUE_DEPTH-entry FIFO that absorbs verdict stalls.
// Reset: arst_n asynchronous, active low; clears pattern registers, parser state,
// FIFO pointers and the verdict valid. No clearing pass.
`default_nettype none
`include "assert_macros.svh"

module ipv4_packet_classifier_with_match_unit #(
	parameter int MAX_PATTERN_BYTES = 8,
	parameter int QUEUE_DEPTH       = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	ipcm_in_if.sink     frame,
	ipcm_out_if.source  verdict,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import ipcm_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t reg_idx;
	logic     cfg_wr;

	logic     push_valid, push_ready;
	qent_t    push_data;
	logic     q_valid, q_ready;
	qent_t    q_data;
	logic     out_valid;
	verdict_t out_data;

	// register map
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_comb begin
		case (reg_idx)
			REG_PLEN:   prdata = {28'b0, cfg_q.pattern_length};
			REG_PWORD0: prdata = cfg_q.pattern_first_word;
			REG_PWORD1: prdata = cfg_q.pattern_second_word;
			default:    prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_PLEN:   cfg_q.pattern_length <= pwdata[3:0];
				REG_PWORD0: cfg_q.pattern_first_word <= pwdata;
				REG_PWORD1: cfg_q.pattern_second_word <= pwdata;
				default:    ;
			endcase
		end
	end

	ipcm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (frame.valid),
		.in_byte    (frame.frame_byte),
		.in_last    (frame.frame_last),
		.in_ready   (frame.ready),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready)
	);

	ipcm_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready),
		.pop_valid  (q_valid),
		.pop_data   (q_data),
		.pop_ready  (q_ready)
	);

	ipcm_back #(
		.MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_data    (q_data),
		.q_ready   (q_ready),
		.cfg       (cfg_q),
		.out_valid (out_valid),
		.out_data  (out_data),
		.out_ready (verdict.ready)
	);

	assign verdict.valid          = out_valid;
	assign verdict.frame_class    = out_data.frame_class;
	assign verdict.header_error   = out_data.header_error;
	assign verdict.truncated      = out_data.truncated;
	assign verdict.payload_offset = out_data.payload_offset;
	assign verdict.payload_length = out_data.payload_length;
	assign verdict.pattern_found  = out_data.pattern_found;
	assign verdict.frame_pass     = out_data.frame_pass;

	`ASSERT_NEXT(a_verdict_load, q_valid && q_ready && q_data.last, verdict.valid, "last byte popped but no verdict")
	`ASSERT_IMPLIES(a_pass_unfiltered, verdict.valid && cfg_q.pattern_length == 4'd0, verdict.frame_pass && !verdict.pattern_found, "filtering off but frame rejected")
	`ASSERT_IMPLIES(a_found_clean, verdict.valid && verdict.pattern_found, !verdict.truncated && verdict.header_error == ERR_NONE && verdict.frame_class >= CLS_TCP, "match on bad frame")
	`ASSERT_IMPLIES(a_len_needs_hdr, verdict.valid && verdict.payload_length != 16'd0, verdict.header_error == ERR_NONE && verdict.payload_offset != 8'd0, "payload length without valid header")

endmodule

`default_nettype wire
